FILE: sv/rwr_pkg.sv
// ----------------------------------------------------------------------------
// Reorder window receiver package
// Request and result types and result kind codes.
// ----------------------------------------------------------------------------
package rwr_pkg;

  localparam int SEQ_W = 32;
  localparam int LEN_W = 11;

  localparam logic [1:0] KIND_DELIVER  = 2'd0;
  localparam logic [1:0] KIND_BUFFERED = 2'd1;
  localparam logic [1:0] KIND_ACK      = 2'd2;

  typedef struct packed {
    logic [31:0]      packet_magic;
    logic [SEQ_W-1:0] seq_number;
    logic [LEN_W-1:0] payload_length;
    logic             end_of_stream;
  } in_req_t;

  typedef struct packed {
    logic [1:0]       result_kind;
    logic [SEQ_W-1:0] result_seq;
    logic [LEN_W-1:0] result_length;
    logic             result_eof;
    logic             last_result;
  } out_res_t;

endpackage

FILE: sv/rwr_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module rwr_ram #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/reorder_window_receiver_core.sv
// ----------------------------------------------------------------------------
// Reorder window receiver core
// Selective-repeat receive window: delivers in-order packets, marks packets
// ahead of the expected sequence, drains buffered slots, acks cumulatively.
// ----------------------------------------------------------------------------
// Flow: an accepted request is registered and evaluated in ST_EVAL, which
//   registers its first result, if any, onto out_res. A dropped or buffered
//   request then returns to idle; an in-order request drains buffered slots
//   in ST_DRAIN, one slot a cycle via the length memory's registered read.
// Reset: synchronous, clears sequencer, expected sequence, slot valid bits,
//   stream done and magic value; the length memory is not cleared.
module reorder_window_receiver_core #(
  parameter int WINDOW_SLOTS = 16,
  parameter int MAX_PAYLOAD  = 1500
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  rwr_pkg::in_req_t  in_req,
  output logic              out_valid,
  output rwr_pkg::out_res_t out_res,
  input  logic              cfg_we,
  input  logic [31:0]       cfg_wdata
);

  localparam int IW = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
  localparam int SW = rwr_pkg::SEQ_W;
  localparam int LW = rwr_pkg::LEN_W;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_EVAL  = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  state_t            state_r, state_nxt;
  rwr_pkg::in_req_t  req_r;
  logic [31:0]       magic_r;
  logic [SW-1:0]     exp_r, exp_nxt;
  logic [IW-1:0]     idx_r, idx_nxt;
  logic [IW-1:0]     cnt_r, cnt_nxt;
  logic [WINDOW_SLOTS-1:0] valid_r, valid_nxt;
  logic              done_r, done_nxt;
  logic              out_valid_r, out_valid_nxt;
  rwr_pkg::out_res_t out_res_r, out_res_nxt;

  logic [SW:0]       diff;
  logic [SW-1:0]     exp_inc;
  logic [IW-1:0]     idx_inc;
  logic [IW:0]       slot_sum;
  logic [IW-1:0]     slot_idx;
  logic [LW-1:0]     len_clamp;
  logic              ram_we;
  logic [LW-1:0]     ram_rdata;
  logic              match, in_order, ahead;

  // shared compare unit
  assign diff     = {1'b0, req_r.seq_number} - {1'b0, exp_r};
  assign match    = !done_r && (req_r.packet_magic == magic_r);
  assign in_order = (diff == '0);
  assign ahead    = !diff[SW] && (diff[SW-1:0] != '0) &&
                    (diff[SW-1:0] < SW'(WINDOW_SLOTS));

  assign exp_inc  = exp_r + SW'(1);
  assign idx_inc  = (exp_r == '1) ? '0 :
                    (idx_r == IW'(WINDOW_SLOTS - 1)) ? '0 : idx_r + IW'(1);

  assign slot_sum = {1'b0, idx_r} + {1'b0, diff[IW-1:0]};
  assign slot_idx = (slot_sum >= (IW+1)'(WINDOW_SLOTS)) ?
                    IW'(slot_sum - (IW+1)'(WINDOW_SLOTS)) : slot_sum[IW-1:0];

  assign len_clamp = (32'(req_r.payload_length) > 32'(MAX_PAYLOAD)) ?
                     LW'(MAX_PAYLOAD) : req_r.payload_length;

  always_comb begin
    state_nxt     = state_r;
    exp_nxt       = exp_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    valid_nxt     = valid_r;
    done_nxt      = done_r;
    out_valid_nxt = 1'b0;
    out_res_nxt   = '0;
    ram_we        = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        state_nxt = ST_IDLE;
        cnt_nxt   = '0;
        if (match && in_order) begin
          out_valid_nxt             = 1'b1;
          out_res_nxt.result_kind   = rwr_pkg::KIND_DELIVER;
          out_res_nxt.result_seq    = req_r.seq_number;
          out_res_nxt.result_length = len_clamp;
          exp_nxt   = exp_inc;
          idx_nxt   = idx_inc;
          state_nxt = ST_DRAIN;
        end else if (match && ahead) begin
          ram_we                  = 1'b1;
          valid_nxt[slot_idx]     = 1'b1;
          out_valid_nxt           = 1'b1;
          out_res_nxt.result_kind = rwr_pkg::KIND_ACK;
          out_res_nxt.result_seq  = exp_r;
          out_res_nxt.result_eof  = req_r.end_of_stream;
          out_res_nxt.last_result = 1'b1;
          done_nxt                = req_r.end_of_stream;
        end
      end
      ST_DRAIN: begin
        out_valid_nxt = 1'b1;
        if (valid_r[idx_r] && (cnt_r != IW'(WINDOW_SLOTS - 1))) begin
          out_res_nxt.result_kind   = rwr_pkg::KIND_BUFFERED;
          out_res_nxt.result_seq    = exp_r;
          out_res_nxt.result_length = ram_rdata;
          valid_nxt[idx_r] = 1'b0;
          exp_nxt = exp_inc;
          idx_nxt = idx_inc;
          cnt_nxt = cnt_r + IW'(1);
        end else begin
          out_res_nxt.result_kind = rwr_pkg::KIND_ACK;
          out_res_nxt.result_seq  = exp_r;
          out_res_nxt.result_eof  = req_r.end_of_stream;
          out_res_nxt.last_result = 1'b1;
          done_nxt  = req_r.end_of_stream;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      magic_r     <= '0;
      exp_r       <= '0;
      idx_r       <= '0;
      cnt_r       <= '0;
      valid_r     <= '0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      exp_r       <= exp_nxt;
      idx_r       <= idx_nxt;
      cnt_r       <= cnt_nxt;
      valid_r     <= valid_nxt;
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        magic_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
    if (state_r == ST_IDLE && start) begin
      req_r <= in_req;
    end
  end

  rwr_ram #(
    .WIDTH (LW),
    .DEPTH (WINDOW_SLOTS)
  ) u_len_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_idx),
    .wdata (len_clamp),
    .raddr (idx_nxt),
    .rdata (ram_rdata)
  );

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

FILE: sv/rwr_checker.sv
// ----------------------------------------------------------------------------
// Reorder window receiver checker
// Port-level properties of the request and result sequence.
// ----------------------------------------------------------------------------
module rwr_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_valid,
  input rwr_pkg::out_res_t out_res
);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request accepted but busy not raised");

  a_ack_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_res.result_kind == rwr_pkg::KIND_ACK) |-> out_res.last_result)
    else $error("ack not marked last");

  a_last_is_ack: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_res.last_result) |-> out_res.result_kind == rwr_pkg::KIND_ACK)
    else $error("last result is not an ack");

  a_ack_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_res.result_kind == rwr_pkg::KIND_ACK) |-> out_res.result_length == '0)
    else $error("ack carries a length");

  a_gap_after_ack: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_res.last_result) |=> !out_valid)
    else $error("result follows ack directly");

endmodule

bind reorder_window_receiver_core rwr_checker u_rwr_checker (.*);

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Reorder window receiver testbench
// Sends packet header requests to the receive window core and checks every
// delivery, drained slot and ack against a window model kept in the bench.
// Runs directed corner cases, then shuffled in-window bursts mixed with
// corrupted, stale and out-of-window headers under three magic settings,
// and closes with an end-of-stream ack that stops the core.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int WINDOW_SLOTS = 16;
  localparam int MAX_PAYLOAD  = 1500;
  localparam int LEN_W        = rwr_pkg::LEN_W;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              start     = 1'b0;
  logic              busy;
  rwr_pkg::in_req_t  in_req    = '0;
  logic              out_valid;
  rwr_pkg::out_res_t out_res;
  logic              cfg_we    = 1'b0;
  logic [31:0]       cfg_wdata = '0;

  rwr_pkg::in_req_t  pending_reqs[$];
  rwr_pkg::out_res_t expected_results[$];
  int unsigned send_idle_pct   = 0;
  int unsigned errors          = 0;
  int unsigned reqs_accepted   = 0;
  int unsigned results_checked = 0;
  int unsigned slots_drained   = 0;

  logic [31:0]      win_magic    = '0;
  logic [31:0]      win_next_seq = '0;
  bit               win_valid[WINDOW_SLOTS];
  bit [LEN_W-1:0]   win_len[WINDOW_SLOTS];
  bit               win_done     = 1'b0;

  reorder_window_receiver_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_res   (out_res),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #10 clk = ~clk;

  task automatic predict_window(input rwr_pkg::in_req_t r);
    logic [LEN_W-1:0] len;
    logic [31:0]      gap;
    int               idx;
    int               drained;
    len     = (r.payload_length > MAX_PAYLOAD) ? LEN_W'(MAX_PAYLOAD) : r.payload_length;
    drained = 0;
    if (win_done || r.packet_magic != win_magic) return;
    if (r.seq_number == win_next_seq) begin
      expected_results.push_back(rwr_pkg::out_res_t'{rwr_pkg::KIND_DELIVER, r.seq_number,
                                                      len, 1'b0, 1'b0});
      win_next_seq++;
      idx = int'(win_next_seq % WINDOW_SLOTS);
      while (drained < WINDOW_SLOTS - 1 && win_valid[idx]) begin
        expected_results.push_back(rwr_pkg::out_res_t'{rwr_pkg::KIND_BUFFERED, win_next_seq,
                                                        win_len[idx], 1'b0, 1'b0});
        win_valid[idx] = 1'b0;
        win_len[idx]   = '0;
        win_next_seq++;
        drained++;
        idx = int'(win_next_seq % WINDOW_SLOTS);
      end
    end else if (r.seq_number < win_next_seq) begin
      return;
    end else begin
      gap = r.seq_number - win_next_seq;
      if (gap >= WINDOW_SLOTS) return;
      idx            = int'(r.seq_number % WINDOW_SLOTS);
      win_valid[idx] = 1'b1;
      win_len[idx]   = len;
    end
    expected_results.push_back(rwr_pkg::out_res_t'{rwr_pkg::KIND_ACK, win_next_seq, '0,
                                                    r.end_of_stream, 1'b1});
    if (r.end_of_stream) win_done = 1'b1;
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // driver: hold the request while busy, advance on acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        predict_window(in_req);
        reqs_accepted++;
      end
      if (!start || !busy) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_req <= pending_reqs.pop_front();
          start  <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    rwr_pkg::out_res_t want;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", 64'(out_res), '0);
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (out_res.result_kind == rwr_pkg::KIND_BUFFERED) slots_drained++;
        if (out_res.result_kind !== want.result_kind)
          report_mismatch("result_kind", out_res.result_kind, want.result_kind);
        if (out_res.result_seq !== want.result_seq)
          report_mismatch("result_seq", out_res.result_seq, want.result_seq);
        if (out_res.result_length !== want.result_length)
          report_mismatch("result_length", out_res.result_length, want.result_length);
        if (out_res.result_eof !== want.result_eof)
          report_mismatch("result_eof", out_res.result_eof, want.result_eof);
        if (out_res.last_result !== want.last_result)
          report_mismatch("last_result", out_res.last_result, want.last_result);
      end
    end
  end

  task automatic queue_req(input logic [31:0] magic, input logic [31:0] seq,
                           input logic [LEN_W-1:0] len, input logic eof);
    pending_reqs.push_back(rwr_pkg::in_req_t'{magic, seq, len, eof});
  endtask

  function automatic logic [LEN_W-1:0] rand_len();
    if ($urandom_range(7) == 0) return LEN_W'($urandom_range(2047, MAX_PAYLOAD + 1));
    return LEN_W'($urandom_range(MAX_PAYLOAD));
  endfunction

  task automatic write_magic(input logic [31:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    win_magic = v;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    while (pending_reqs.size() != 0 || start || expected_results.size() != 0 || busy)
      @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // shuffled bursts inside the window, with corrupted, stale, out-of-window
  // and duplicate headers mixed in
  task automatic gen_traffic(input int target);
    logic [31:0] base;
    logic [31:0] s;
    logic [31:0] order[$];
    int          k;
    int          j;
    int          count;
    count = 0;
    base  = win_next_seq;
    while (count < target) begin
      k = $urandom_range(15, 1);
      order.delete();
      for (int i = 0; i < k; i++) order.push_back(base + i);
      for (int i = k - 1; i > 0; i--) begin
        j        = $urandom_range(i, 0);
        s        = order[i];
        order[i] = order[j];
        order[j] = s;
      end
      for (int i = 0; i < k; i++) begin
        queue_req(win_magic, order[i], rand_len(), 1'b0);
        count++;
        case ($urandom_range(11))
          0: begin
            s = $urandom_range(1) ? $urandom : base + $urandom_range(15);
            queue_req(win_magic ^ ($urandom | 32'h1), s, rand_len(), 1'($urandom_range(1)));
          end
          1: begin
            if (base != 0)
              queue_req(win_magic, base - $urandom_range(base > 40 ? 40 : base, 1),
                        rand_len(), 1'($urandom_range(1)));
          end
          2: begin
            s = $urandom;
            if (s - base < 48) s = base + 48 + s[5:0];
            queue_req(win_magic, s, rand_len(), 1'($urandom_range(1)));
          end
          3: queue_req(win_magic, order[$urandom_range(i, 0)], rand_len(), 1'b0);
          default: ;
        endcase
      end
      base += k;
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    write_magic(32'h0);
    queue_req(32'hFFFF_FFFF, 32'd0, 11'd2047, 1'b1);
    queue_req(32'h0, 32'd0, 11'd0, 1'b0);
    queue_req(32'h0, 32'd1, 11'd2047, 1'b0);
    queue_req(32'h0, 32'hFFFF_FFFF, 11'd1500, 1'b1);
    queue_req(32'h0, 32'd0, 11'd5, 1'b1);
    queue_req(32'h0, 32'd18, 11'd7, 1'b1);
    queue_req(32'h0, 32'd17, 11'd1501, 1'b0);
    queue_req(32'h0, 32'd5, 11'd0, 1'b0);
    queue_req(32'h0, 32'd4, 11'd1, 1'b0);
    queue_req(32'h0, 32'd4, 11'd1500, 1'b0);
    for (int s = 16; s >= 6; s--) queue_req(32'h0, s, rand_len(), 1'b0);
    queue_req(32'h0, 32'd3, 11'd10, 1'b0);
    queue_req(32'h0, 32'd2, 11'd1500, 1'b0);
    wait_idle();

    write_magic(32'hFFFF_FFFF);
    send_idle_pct = 24;
    gen_traffic(20);
    wait_idle();

    write_magic($urandom);
    send_idle_pct = 61;
    gen_traffic(20);
    wait_idle();

    write_magic($urandom);
    send_idle_pct = 0;
    gen_traffic(20);
    wait_idle();

    // buffered end of stream stops the core; nothing after it is answered
    queue_req(win_magic, win_next_seq + 2, rand_len(), 1'b1);
    queue_req(win_magic, win_next_seq, rand_len(), 1'b0);
    queue_req(win_magic, win_next_seq + 1, rand_len(), 1'b1);
    wait_idle();

    if (expected_results.size() != 0)
      report_mismatch("results never seen", expected_results.size(), '0);
    $display("Covered %0d requests and %0d checked results, %0d of them drained slots.",
             reqs_accepted, results_checked, slots_drained);
    $display("Directed corners, three magic settings with sender gaps, end of stream.");
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timeout waiting for the receive window to finish");
    $display("Test completed with failures");
    $finish;
  end

endmodule
